### rtl/multichannel_pid_heater_defines.svh
// Assertion helpers for the RTL controller (mph_ctrl).
`ifndef MULTICHANNEL_PID_HEATER_DEFINES_SVH
`define MULTICHANNEL_PID_HEATER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define MPH_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mph: same-cycle check failed");

// Next-cycle implication, held off while reset is asserted.
`define MPH_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mph: next-cycle check failed");

`endif

### rtl/mph_pkg.sv
`default_nettype none

package mph_pkg;

    // Divider geometry: 64-bit dividend, 16-bit divisor, two quotient bits per cycle.
    localparam int DIV_W = 64;
    localparam int DVS_W = 16;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_CYC_I = 6'd32;  // 64-bit integral product
    localparam logic [DIV_CNT_W-1:0] DIV_CYC_D = 6'd14;  // 28-bit derivative numerator

    localparam logic [15:0] MS_PER_S = 16'd1000;

    localparam logic [47:0] ACC_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0] ACC_MIN = {1'b1, 47'd0};

    // Configuration register indexes
    localparam logic [2:0] REG_SP_CH0 = 3'd0;
    localparam logic [2:0] REG_SP_CH1 = 3'd1;
    localparam logic [2:0] REG_SP_CH2 = 3'd2;
    localparam logic [2:0] REG_SP_CH3 = 3'd3;
    localparam logic [2:0] REG_GAIN_P = 3'd4;
    localparam logic [2:0] REG_GAIN_I = 3'd5;
    localparam logic [2:0] REG_GAIN_D = 3'd6;

    localparam logic [15:0] SP_CH0_RST = 16'd640;
    localparam logic [15:0] SP_CH1_RST = 16'd640;
    localparam logic [15:0] SP_CH2_RST = 16'd480;
    localparam logic [15:0] SP_CH3_RST = 16'd480;
    localparam logic [15:0] GAIN_P_RST = 16'd3072;
    localparam logic [15:0] GAIN_I_RST = 16'd128;
    localparam logic [15:0] GAIN_D_RST = 16'd7680;

    typedef enum logic [2:0] {
        MUL_NONE   = 3'd0,
        MUL_E_DT   = 3'd1,
        MUL_GP_E   = 3'd2,
        MUL_GI_LO  = 3'd3,
        MUL_GI_HI  = 3'd4,
        MUL_DIFF_K = 3'd5,
        MUL_GD_D   = 3'd6
    } mul_op_t;

    typedef enum logic [1:0] {
        SUM_HOLD   = 2'd0,
        SUM_LOAD_P = 2'd1,
        SUM_ADD_I  = 2'd2,
        SUM_ADD_D  = 2'd3
    } sum_op_t;

    typedef struct packed {
        logic    capture;
        logic    load;
        logic    acc_upd;
        logic    mag_load;
        logic    plo_load;
        mul_op_t mul_op;
        sum_op_t sum_op;
        logic    div_start_i;
        logic    div_start_d;
        logic    commit;
    } mph_cmd_t;

    typedef struct packed {
        logic skip;
        logic div_busy;
        logic div_last;
        logic out_free;
    } mph_sts_t;

endpackage

`default_nettype wire

### rtl/mph_div.sv
`default_nettype none

module mph_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [mph_pkg::DIV_W-1:0]           dividend,
    input  wire logic [mph_pkg::DVS_W-1:0]           divisor,
    input  wire logic [mph_pkg::DIV_CNT_W-1:0]       cycles,
    output logic      [mph_pkg::DIV_W-1:0]           quotient,
    output logic                                     busy,
    output logic                                     last
);

    logic [mph_pkg::DVS_W-1:0]     rem_reg;
    logic [mph_pkg::DIV_W-1:0]     quo_reg;
    logic [mph_pkg::DVS_W-1:0]     dvs_reg;
    logic [mph_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic [mph_pkg::DVS_W:0]   r1, r2, s1, s2;
    logic                      q1, q2;
    logic [mph_pkg::DVS_W-1:0] rem_next;
    logic [mph_pkg::DIV_W-1:0] quo_next;

    // Two restoring steps per cycle
    always_comb begin
        r1 = {rem_reg, quo_reg[mph_pkg::DIV_W-1]};
        q1 = (r1 >= {1'b0, dvs_reg});
        s1 = q1 ? (r1 - {1'b0, dvs_reg}) : r1;
        r2 = {s1[mph_pkg::DVS_W-1:0], quo_reg[mph_pkg::DIV_W-2]};
        q2 = (r2 >= {1'b0, dvs_reg});
        s2 = q2 ? (r2 - {1'b0, dvs_reg}) : r2;
        rem_next = s2[mph_pkg::DVS_W-1:0];
        quo_next = {quo_reg[mph_pkg::DIV_W-3:0], q1, q2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= cycles;
        end else if (busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign last     = (cnt_reg == mph_pkg::DIV_CNT_W'(1));
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/mph_dpath.sv
`default_nettype none

module mph_dpath #(
    parameter int CHANNELS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire mph_pkg::mph_cmd_t  cmd_i,
    output mph_pkg::mph_sts_t       sts_o,
    input  wire logic [1:0]         s_channel,
    input  wire logic signed [15:0] s_temperature,
    input  wire logic [31:0]        s_time_ms,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_out_channel,
    output logic [7:0]              m_duty
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    logic [15:0] sp_reg [4];
    logic [15:0] gp_reg, gi_reg, gd_reg;

    // Captured sample
    logic [1:0]  ch_reg;
    logic [15:0] temp_reg;
    logic [31:0] time_reg;

    // Per-channel state
    logic [47:0] integ_reg [CHANNELS];
    logic [17:0] perr_reg  [CHANNELS];
    logic [31:0] ptime_reg [CHANNELS];

    // Working registers
    logic [15:0]        dt_reg;
    logic [16:0]        e_reg;
    logic [17:0]        diff_reg;
    logic [47:0]        acc_old_reg, acc_new_reg, acc_mag_reg;
    logic [39:0]        plo_reg;
    logic signed [45:0] prod_reg;
    logic [63:0]        sum_reg;
    logic               out_valid_reg;
    logic [1:0]         out_ch_reg;
    logic [7:0]         duty_reg;

    logic [IDX_W-1:0]   idx;
    logic [31:0]        dt_raw;
    logic [15:0]        dt_next;
    logic [16:0]        e_next;
    logic [17:0]        diff_next;
    logic               ch_ok;
    logic [48:0]        acc_sum;
    logic [47:0]        acc_sat;
    logic [47:0]        acc_mag_next;
    logic signed [16:0] mul_a;
    logic signed [28:0] mul_b;
    logic signed [45:0] prod_next;
    logic [63:0]        prod_ext;
    logic [63:0]        pmag;
    logic [45:0]        dk_mag;
    logic [63:0]        sum_next;
    logic [7:0]         duty_next;

    logic                          div_start;
    logic [mph_pkg::DIV_W-1:0]     div_dividend;
    logic [mph_pkg::DVS_W-1:0]     div_divisor;
    logic [mph_pkg::DIV_CNT_W-1:0] div_cycles;
    logic [mph_pkg::DIV_W-1:0]     div_quo;
    logic                          div_busy, div_last;

    mph_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .cycles   (div_cycles),
        .quotient (div_quo),
        .busy     (div_busy),
        .last     (div_last)
    );

    // Sample setup
    always_comb begin
        idx       = IDX_W'(ch_reg);
        ch_ok     = (int'(ch_reg) < CHANNELS);
        dt_raw    = time_reg - ptime_reg[idx];
        dt_next   = (|dt_raw[31:16]) ? 16'hFFFF : dt_raw[15:0];
        e_next    = {sp_reg[ch_reg][15], sp_reg[ch_reg]} - {temp_reg[15], temp_reg};
        diff_next = {e_next[16], e_next} - perr_reg[idx];
    end

    // Integral accumulate with saturation
    always_comb begin
        acc_sum = {acc_old_reg[47], acc_old_reg} + {{3{prod_reg[45]}}, prod_reg};
        if (acc_sum[48] != acc_sum[47]) begin
            acc_sat = acc_sum[48] ? mph_pkg::ACC_MIN : mph_pkg::ACC_MAX;
        end else begin
            acc_sat = acc_sum[47:0];
        end
        acc_mag_next = acc_new_reg[47] ? (48'd0 - acc_new_reg) : acc_new_reg;
    end

    // Shared multiplier
    always_comb begin
        unique case (cmd_i.mul_op)
            mph_pkg::MUL_E_DT: begin
                mul_a = e_reg;
                mul_b = {13'd0, dt_reg};
            end
            mph_pkg::MUL_GP_E: begin
                mul_a = e_reg;
                mul_b = {13'd0, gp_reg};
            end
            mph_pkg::MUL_GI_LO: begin
                mul_a = {1'b0, gi_reg};
                mul_b = {5'd0, acc_mag_reg[23:0]};
            end
            mph_pkg::MUL_GI_HI: begin
                mul_a = {1'b0, gi_reg};
                mul_b = {5'd0, acc_mag_reg[47:24]};
            end
            mph_pkg::MUL_DIFF_K: begin
                mul_a = {1'b0, mph_pkg::MS_PER_S};
                mul_b = {{11{diff_reg[17]}}, diff_reg};
            end
            mph_pkg::MUL_GD_D: begin
                mul_a = {1'b0, gd_reg};
                mul_b = {1'b0, div_quo[27:0]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    // Divider operands and running sum
    always_comb begin
        prod_ext     = {{18{prod_reg[45]}}, prod_reg};
        pmag         = {24'd0, plo_reg} + {prod_reg[39:0], 24'd0};
        dk_mag       = diff_reg[17] ? (46'd0 - prod_reg) : prod_reg;
        div_start    = cmd_i.div_start_i || cmd_i.div_start_d;
        div_dividend = cmd_i.div_start_i ? pmag : {dk_mag[27:0], 36'd0};
        div_divisor  = cmd_i.div_start_i ? mph_pkg::MS_PER_S : dt_reg;
        div_cycles   = cmd_i.div_start_i ? mph_pkg::DIV_CYC_I : mph_pkg::DIV_CYC_D;

        unique case (cmd_i.sum_op)
            mph_pkg::SUM_LOAD_P: sum_next = prod_ext;
            // integral term carries the sign of the accumulator
            mph_pkg::SUM_ADD_I:  sum_next = acc_new_reg[47] ? (sum_reg - div_quo)
                                                            : (sum_reg + div_quo);
            // derivative term carries the sign of the error change
            mph_pkg::SUM_ADD_D:  sum_next = diff_reg[17] ? (sum_reg - prod_ext)
                                                         : (sum_reg + prod_ext);
            default:             sum_next = sum_reg;
        endcase

        if (sum_reg[63]) begin
            duty_next = 8'd0;
        end else if (|sum_reg[62:20]) begin
            duty_next = 8'hFF;
        end else begin
            duty_next = sum_reg[19:12];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg[0] <= mph_pkg::SP_CH0_RST;
            sp_reg[1] <= mph_pkg::SP_CH1_RST;
            sp_reg[2] <= mph_pkg::SP_CH2_RST;
            sp_reg[3] <= mph_pkg::SP_CH3_RST;
            gp_reg    <= mph_pkg::GAIN_P_RST;
            gi_reg    <= mph_pkg::GAIN_I_RST;
            gd_reg    <= mph_pkg::GAIN_D_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mph_pkg::REG_SP_CH0: sp_reg[0] <= cfg_data;
                mph_pkg::REG_SP_CH1: sp_reg[1] <= cfg_data;
                mph_pkg::REG_SP_CH2: sp_reg[2] <= cfg_data;
                mph_pkg::REG_SP_CH3: sp_reg[3] <= cfg_data;
                mph_pkg::REG_GAIN_P: gp_reg    <= cfg_data;
                mph_pkg::REG_GAIN_I: gi_reg    <= cfg_data;
                mph_pkg::REG_GAIN_D: gd_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Channel state: update on commit only
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                integ_reg[i] <= '0;
                perr_reg[i]  <= '0;
                ptime_reg[i] <= '0;
            end
        end else if (cmd_i.commit) begin
            integ_reg[idx] <= acc_new_reg;
            perr_reg[idx]  <= {e_reg[16], e_reg};
            ptime_reg[idx] <= time_reg;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            ch_reg   <= s_channel;
            temp_reg <= s_temperature;
            time_reg <= s_time_ms;
        end
        if (cmd_i.load) begin
            dt_reg      <= dt_next;
            e_reg       <= e_next;
            diff_reg    <= diff_next;
            acc_old_reg <= integ_reg[idx];
        end
        if (cmd_i.acc_upd) begin
            acc_new_reg <= acc_sat;
        end
        if (cmd_i.mag_load) begin
            acc_mag_reg <= acc_mag_next;
        end
        if (cmd_i.plo_load) begin
            plo_reg <= prod_reg[39:0];
        end
        if (cmd_i.mul_op != mph_pkg::MUL_NONE) begin
            prod_reg <= prod_next;
        end
        sum_reg <= sum_next;
        if (cmd_i.commit) begin
            out_ch_reg <= ch_reg;
            duty_reg   <= duty_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd_i.commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb begin
        sts_o.skip     = !ch_ok || (dt_raw == 32'd0);
        sts_o.div_busy = div_busy;
        sts_o.div_last = div_last;
        sts_o.out_free = !out_valid_reg || m_ready;
    end

    assign m_valid       = out_valid_reg;
    assign m_out_channel = out_ch_reg;
    assign m_duty        = duty_reg;

endmodule

`default_nettype wire

### rtl/mph_ctrl.sv
`default_nettype none
`include "multichannel_pid_heater_defines.svh"

module mph_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output mph_pkg::mph_cmd_t      cmd_o,
    input  wire mph_pkg::mph_sts_t sts_i
);

    typedef enum logic [13:0] {
        ST_IDLE     = 14'h0001,
        ST_LOAD     = 14'h0002,
        ST_MUL_EDT  = 14'h0004,
        ST_ACC      = 14'h0008,
        ST_ABS      = 14'h0010,
        ST_MUL_ILO  = 14'h0020,
        ST_MUL_IHI  = 14'h0040,
        ST_DIV_I_GO = 14'h0080,
        ST_DIV_I    = 14'h0100,
        ST_ADD_I    = 14'h0200,
        ST_DIV_D    = 14'h0400,
        ST_MUL_D    = 14'h0800,
        ST_ADD_D    = 14'h1000,
        ST_DONE     = 14'h2000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd_o      = '0;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_o.capture = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd_o.load = 1'b1;
                // drop samples with no elapsed time or an unused channel
                state_next = sts_i.skip ? ST_IDLE : ST_MUL_EDT;
            end
            ST_MUL_EDT: begin
                cmd_o.mul_op = mph_pkg::MUL_E_DT;
                state_next   = ST_ACC;
            end
            ST_ACC: begin
                cmd_o.acc_upd = 1'b1;
                cmd_o.mul_op  = mph_pkg::MUL_GP_E;
                state_next    = ST_ABS;
            end
            ST_ABS: begin
                cmd_o.mag_load = 1'b1;
                cmd_o.sum_op   = mph_pkg::SUM_LOAD_P;
                state_next     = ST_MUL_ILO;
            end
            ST_MUL_ILO: begin
                cmd_o.mul_op = mph_pkg::MUL_GI_LO;
                state_next   = ST_MUL_IHI;
            end
            ST_MUL_IHI: begin
                cmd_o.plo_load = 1'b1;
                cmd_o.mul_op   = mph_pkg::MUL_GI_HI;
                state_next     = ST_DIV_I_GO;
            end
            ST_DIV_I_GO: begin
                cmd_o.div_start_i = 1'b1;
                cmd_o.mul_op      = mph_pkg::MUL_DIFF_K;
                state_next        = ST_DIV_I;
            end
            ST_DIV_I: begin
                if (sts_i.div_last) begin
                    state_next = ST_ADD_I;
                end
            end
            ST_ADD_I: begin
                cmd_o.sum_op      = mph_pkg::SUM_ADD_I;
                cmd_o.div_start_d = 1'b1;
                state_next        = ST_DIV_D;
            end
            ST_DIV_D: begin
                if (sts_i.div_last) begin
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                cmd_o.mul_op = mph_pkg::MUL_GD_D;
                state_next   = ST_ADD_D;
            end
            ST_ADD_D: begin
                cmd_o.sum_op = mph_pkg::SUM_ADD_D;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                // hold until the result register can take the transaction
                if (sts_i.out_free) begin
                    cmd_o.commit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `MPH_ASSERT_NXT(a_ready_drops, aclk, aresetn, s_valid && s_ready, !s_ready)
    `MPH_ASSERT_IMP(a_div_idle_at_start, aclk, aresetn, cmd_o.div_start_i || cmd_o.div_start_d, !sts_i.div_busy)
    `MPH_ASSERT_IMP(a_wait_sees_div, aclk, aresetn, state_reg == ST_DIV_I || state_reg == ST_DIV_D, sts_i.div_busy)
    `MPH_ASSERT_IMP(a_commit_free, aclk, aresetn, cmd_o.commit, sts_i.out_free)

endmodule

`default_nettype wire

### rtl/multichannel_pid_heater.sv
// Port group  Dir  Handshake            Payload
// s_          in   s_valid / s_ready    s_channel, s_temperature, s_time_ms
// m_          out  m_valid / m_ready    m_out_channel, m_duty
// cfg_        in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// A sample holds s_ready low from acceptance until it returns; its result is
// registered in the same cycle that s_ready returns. The shared radix-4 divider sets this:
// it divides the integral product by 1000 and the derivative by dt.
// A sample with zero elapsed time or an unused channel is dropped without a result.
// aresetn (synchronous, active low) restores setpoints and gains and clears all
// channel state. A stalled result waits in its register while the next sample is
// taken; the controller holds in its last state only if that register is still full.
`default_nettype none

module multichannel_pid_heater #(
    parameter int CHANNELS = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_channel,
    input  wire logic signed [15:0] s_temperature,
    input  wire logic [31:0]        s_time_ms,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_out_channel,
    output logic [7:0]              m_duty,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [15:0]        cfg_data
);

    mph_pkg::mph_cmd_t cmd;
    mph_pkg::mph_sts_t sts;

    assign cfg_ready = 1'b1;

    mph_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd_o   (cmd),
        .sts_i   (sts)
    );

    mph_dpath #(
        .CHANNELS (CHANNELS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_i         (cmd),
        .sts_o         (sts),
        .s_channel     (s_channel),
        .s_temperature (s_temperature),
        .s_time_ms     (s_time_ms),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_duty        (m_duty)
    );

endmodule

`default_nettype wire

### bench/tb_multichannel_pid_heater.sv
`default_nettype none

module tb_multichannel_pid_heater;
    import mph_pkg::*;

    localparam int CHANNELS = 4;
    localparam int STALE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 64;
    localparam int RESULTS_PER_PHASE = 116;
    localparam int RANDOM_PHASES = 8;
    localparam int NDIR = 19;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam longint MS_PER_SEC = 1000;
    localparam longint DT_SAT = 65535;
    localparam longint DUTY_TOP = 255;
    localparam longint INTEG_HI = (64'sd1 <<< 47) - 64'sd1;
    localparam longint INTEG_LO = -(64'sd1 <<< 47);

    typedef enum logic [1:0] {
        CHK_MODEL,  // expected duty comes from the predictor
        CHK_QUIET,  // no result may come
        CHK_DUTY    // expected duty typed into the row
    } row_kind_t;

    typedef struct {
        logic [1:0]         ch;
        logic signed [15:0] temp;
        logic [31:0]        stamp;
        row_kind_t          kind;
        logic [7:0]         duty;
    } sample_row_t;

    typedef struct {
        logic [1:0] ch;
        logic [7:0] duty;
    } duty_rec_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_channel = '0;
    logic signed [15:0] s_temperature = '0;
    logic [31:0]        s_time_ms = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_out_channel;
    logic [7:0]         m_duty;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // Controller copy: configuration and per-channel state
    logic [15:0]        setpoint [CHANNELS];
    logic [15:0]        kp, ki, kd;
    logic signed [47:0] err_integral [CHANNELS];
    logic signed [17:0] last_err [CHANNELS];
    logic [31:0]        last_stamp [CHANNELS];

    duty_rec_t   pending_duty [$];
    int unsigned fails = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;

    sample_row_t plan [0:NDIR-1] = '{
        '{2'd0, 16'h0000, 32'd0,          CHK_QUIET, 8'd0},   // zero elapsed after reset
        '{2'd0, 16'h8000, 32'd1,          CHK_DUTY,  8'd255}, // coldest reading
        '{2'd0, 16'h8000, 32'd1,          CHK_QUIET, 8'd0},   // repeated timestamp
        '{2'd1, 16'h7FFF, 32'd1,          CHK_DUTY,  8'd0},   // hottest reading
        '{2'd2, 16'd480,  32'hFFFF_FFFF,  CHK_DUTY,  8'd0},   // long gap, no error
        '{2'd2, 16'd480,  32'd0,          CHK_DUTY,  8'd0},   // timestamp wraps
        '{2'd3, 16'd0,    32'd100,        CHK_MODEL, 8'd0},
        '{2'd3, 16'd480,  32'd350,        CHK_MODEL, 8'd0},
        '{2'd3, 16'd500,  32'd700,        CHK_MODEL, 8'd0},
        '{2'd0, 16'd640,  32'd65537,      CHK_MODEL, 8'd0},   // gap of exactly 65536
        '{2'd1, 16'hFFFF, 32'd70001,      CHK_MODEL, 8'd0},
        '{2'd1, 16'h5555, 32'd70301,      CHK_MODEL, 8'd0},
        '{2'd2, 16'hAAAA, 32'd250,        CHK_MODEL, 8'd0},
        '{2'd0, 16'd600,  32'd65837,      CHK_MODEL, 8'd0},
        '{2'd0, 16'd620,  32'd66137,      CHK_MODEL, 8'd0},
        '{2'd3, 16'd470,  32'h8000_0000,  CHK_MODEL, 8'd0},
        '{2'd3, 16'd475,  32'h8000_0000,  CHK_QUIET, 8'd0},   // same stamp, new reading
        '{2'd1, 16'h7FFF, 32'd70302,      CHK_MODEL, 8'd0},
        '{2'd2, 16'h8000, 32'h5555_5555,  CHK_MODEL, 8'd0}
    };

    multichannel_pid_heater #(
        .CHANNELS(CHANNELS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_channel    (s_channel),
        .s_temperature(s_temperature),
        .s_time_ms    (s_time_ms),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_channel(m_out_channel),
        .m_duty       (m_duty),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic void clear_controller();
        setpoint[0] = SP_CH0_RST;
        setpoint[1] = SP_CH1_RST;
        setpoint[2] = SP_CH2_RST;
        setpoint[3] = SP_CH3_RST;
        kp = GAIN_P_RST;
        ki = GAIN_I_RST;
        kd = GAIN_D_RST;
        for (int c = 0; c < CHANNELS; c++) begin
            err_integral[c] = '0;
            last_err[c] = '0;
            last_stamp[c] = '0;
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            REG_SP_CH0, REG_SP_CH1, REG_SP_CH2, REG_SP_CH3: setpoint[idx[1:0]] = val;
            REG_GAIN_P: kp = val;
            REG_GAIN_I: ki = val;
            REG_GAIN_D: kd = val;
            default: ;
        endcase
    endfunction

    // Advance one channel of the controller; return 1 when a duty comes out.
    function automatic bit pid_duty(input logic [1:0] ch, input logic signed [15:0] temp,
                                    input logic [31:0] now, output logic [7:0] duty);
        logic [31:0] span;
        longint      dt, err, integ, slope, total, level;
        span = now - last_stamp[ch];
        duty = '0;
        if (span == 32'd0) return 1'b0;
        dt = span;
        if (dt > DT_SAT) dt = DT_SAT;
        err = longint'($signed(setpoint[ch])) - longint'(temp);
        integ = longint'(err_integral[ch]) + err * dt;
        if (integ > INTEG_HI) integ = INTEG_HI;
        if (integ < INTEG_LO) integ = INTEG_LO;
        slope = ((err - longint'(last_err[ch])) * MS_PER_SEC) / dt;
        total = longint'(kp) * err + (longint'(ki) * integ) / MS_PER_SEC
              + longint'(kd) * slope;
        if (total < 0) begin
            level = 0;
        end else begin
            level = total >>> 12;
            if (level > DUTY_TOP) level = DUTY_TOP;
        end
        err_integral[ch] = integ[47:0];
        last_err[ch] = err[17:0];
        last_stamp[ch] = now;
        duty = level[7:0];
        return 1'b1;
    endfunction

    // Result side: check each transaction against the oldest expectation
    always @(posedge aclk) begin
        duty_rec_t exp_rec;
        if (aresetn && m_valid && m_ready) begin
            if (pending_duty.size() == 0) begin
                $error("unexpected result: out_channel %0d duty %0d", m_out_channel, m_duty);
                fails++;
            end else begin
                exp_rec = pending_duty.pop_front();
                if (m_out_channel !== exp_rec.ch) begin
                    $error("out_channel: expected %0d, actual %0d", exp_rec.ch, m_out_channel);
                    fails++;
                end
                if (m_duty !== exp_rec.duty) begin
                    $error("duty: expected %0d, actual %0d", exp_rec.duty, m_duty);
                    fails++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    initial begin : watchdog
        int stale;
        stale = 0;
        while (stale < STALE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
                stale = 0;
            else
                stale++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Offer one sample; on acceptance run the controller copy.
    task automatic offer_sample(input logic [1:0] ch, input logic signed [15:0] temp,
                                input logic [31:0] stamp, output bit made,
                                output logic [7:0] duty);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_channel <= ch;
        s_temperature <= temp;
        s_time_ms <= stamp;
        do @(posedge aclk); while (!s_ready);
        made = pid_duty(ch, temp, stamp, duty);
    endtask

    // Hold the sender off until every expected duty is in, then wait out the tail.
    task automatic settle(input int tail);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_duty.size() != 0);
        repeat (tail) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, val);
    endtask

    task automatic configure(input int phase);
        logic [15:0] val;
        settle(SETTLE_CYCLES);
        for (int r = int'(REG_SP_CH0); r <= int'(REG_UNUSED); r++) begin
            val = 16'($urandom);
            case (3'(r))
                REG_SP_CH0, REG_SP_CH1, REG_SP_CH2, REG_SP_CH3: begin
                    if (phase == 1) val = 16'h7FFF;
                    else if (phase == 2) val = 16'h8000;
                    else if (phase == 3) val = (r < 2) ? SP_CH0_RST : SP_CH2_RST;
                    else if (phase != 6) val = 16'($urandom_range(960, 320));
                end
                REG_GAIN_P: begin
                    if (phase == 1) val = 16'hFFFF;
                    else if (phase == 2) val = 16'h0000;
                    else if (phase == 3) val = GAIN_P_RST;
                    else if (phase != 6) val = 16'($urandom_range(8191, 0));
                end
                REG_GAIN_I: begin
                    if (phase == 1) val = 16'hFFFF;
                    else if (phase == 2) val = 16'h0000;
                    else if (phase == 3) val = GAIN_I_RST;
                    else if (phase != 6) val = 16'($urandom_range(1023, 0));
                end
                REG_GAIN_D: begin
                    if (phase == 1) val = 16'hFFFF;
                    else if (phase == 2) val = 16'h0000;
                    else if (phase == 3) val = GAIN_D_RST;
                    else if (phase != 6) val = 16'($urandom_range(16383, 0));
                end
                default: ;  // unused index keeps its random data
            endcase
            write_reg(3'(r), val);
        end
        cfg_valid <= 1'b0;
    endtask

    // Mostly plausible samples for one channel, with some broken timing and noise.
    task automatic pick_sample(output logic [1:0] ch, output logic signed [15:0] temp,
                               output logic [31:0] stamp);
        int     pick;
        longint t;
        ch = 2'($urandom_range(CHANNELS - 1, 0));
        pick = $urandom_range(99);
        t = longint'($signed(setpoint[ch])) + longint'($urandom_range(256, 0)) - 128;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        temp = 16'(t);
        if (pick < 75) begin
            stamp = last_stamp[ch] + 32'($urandom_range(1000, 50));
        end else if (pick < 80) begin
            stamp = last_stamp[ch];
        end else if (pick < 85) begin
            stamp = last_stamp[ch] + 32'($urandom_range(32'h7FFF_FFFF, 65536));
        end else if (pick < 90) begin
            stamp = 32'hFFFF_FFFF - 32'($urandom_range(500, 0));
        end else begin
            temp = 16'($urandom);
            stamp = $urandom;
        end
    endtask

    initial begin : stimulus
        logic [1:0]         ch;
        logic signed [15:0] temp;
        logic [31:0]        stamp;
        logic [7:0]         duty;
        bit                 made;
        int                 produced;
        clear_controller();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NDIR; i++) begin
            offer_sample(plan[i].ch, plan[i].temp, plan[i].stamp, made, duty);
            case (plan[i].kind)
                CHK_DUTY:  pending_duty.push_back('{plan[i].ch, plan[i].duty});
                CHK_MODEL: if (made) pending_duty.push_back('{plan[i].ch, duty});
                default: ;
            endcase
        end

        for (int p = 1; p <= RANDOM_PHASES; p++) begin
            configure(p);
            case ((p - 1) % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 79; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 79; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            produced = 0;
            while (produced < RESULTS_PER_PHASE) begin
                pick_sample(ch, temp, stamp);
                offer_sample(ch, temp, stamp, made, duty);
                if (made) begin
                    pending_duty.push_back('{ch, duty});
                    produced++;
                    // drain midway so the block restarts from empty
                    if (produced == RESULTS_PER_PHASE / 2) settle(0);
                end
            end
        end

        settle(SETTLE_CYCLES);
        if (fails == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
